// ===== rtl/srm_spmv_pkg.sv =====
`timescale 1ns / 1ps

package srm_spmv_pkg;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_GET     = 3'd2;
    localparam logic [2:0] OP_LOAD    = 3'd3;
    localparam logic [2:0] OP_APPLY   = 3'd4;
    localparam logic [2:0] OP_APPLY_T = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {
        EA_J   = 2'd0,
        EA_JM1 = 2'd1,
        EA_INS = 2'd2,
        EA_HIT = 2'd3
    } ea_sel_t;

    typedef enum logic [1:0] {
        EK_SIMPLE = 2'd0,
        EK_ROW    = 2'd1,
        EK_COL    = 2'd2
    } emit_kind_t;

    typedef struct packed {
        logic       capture;
        logic       clr_rows;
        logic       vec_wr;
        logic       rd_count;
        logic       latch_n;
        logic       rd_entry;
        ea_sel_t    ea_sel;
        logic       ent_wr;
        logic       ent_wr_shift;
        logic       scan;
        logic       cnt_wr;
        logic       j_inc;
        logic       j_dec;
        logic       i_inc;
        logic       i_clr;
        logic       rd_vec;
        logic       vec_addr_i;
        logic       mul;
        logic       acc_clr;
        logic       acc_add;
        logic       tacc_clr_all;
        logic       rd_tacc;
        logic       tacc_addr_i;
        logic       tacc_wr;
        logic       emit;
        emit_kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       sg_in_range;
        logic       j_done;
        logic       j_at_ins;
        logic       found;
        logic       full;
        logic       i_done;
        logic       last_row;
        logic       last_col;
        logic       out_free;
    } sts_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] s);
        sat_t r;
        begin
            r.sat = 1'b0;
            if (s > SUM_MAX)
            begin
                r.value = 32'h7fffffff;
                r.sat   = 1'b1;
            end
            else if (s < SUM_MIN)
            begin
                r.value = 32'h80000000;
                r.sat   = 1'b1;
            end
            else
            begin
                r.value = s[31:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/srm_spmv_ctrl.sv =====
`timescale 1ns / 1ps

module srm_spmv_ctrl
    import srm_spmv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [22:0] {
        S_IDLE       = 23'd1,
        S_DISPATCH   = 23'd2,
        S_CNT_LATCH  = 23'd4,
        S_SCAN_RD    = 23'd8,
        S_SCAN_CHK   = 23'd16,
        S_SET_DECIDE = 23'd32,
        S_SHIFT_RD   = 23'd64,
        S_SHIFT_WR   = 23'd128,
        S_EMIT       = 23'd256,
        S_A_ROW      = 23'd512,
        S_A_CNT      = 23'd1024,
        S_A_ENT      = 23'd2048,
        S_A_VEC      = 23'd4096,
        S_A_MUL      = 23'd8192,
        S_A_ACC      = 23'd16384,
        S_A_EMIT     = 23'd32768,
        S_T_ROW      = 23'd65536,
        S_T_CNT      = 23'd131072,
        S_T_ENT      = 23'd262144,
        S_T_ACC_RD   = 23'd524288,
        S_T_ACC_WR   = 23'd1048576,
        S_T_COL      = 23'd2097152,
        S_T_COL_EMIT = 23'd4194304
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clr_rows = 1'b1;
                        state_next   = S_EMIT;
                    end
                    OP_LOAD:
                    begin
                        cmd.vec_wr = 1'b1;
                        state_next = S_EMIT;
                    end
                    OP_SET, OP_GET:
                    begin
                        if (sts.sg_in_range)
                        begin
                            cmd.rd_count = 1'b1;
                            state_next   = S_CNT_LATCH;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    OP_APPLY:
                    begin
                        state_next = S_A_ROW;
                    end
                    OP_APPLY_T:
                    begin
                        cmd.tacc_clr_all = 1'b1;
                        state_next       = S_T_ROW;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_CNT_LATCH:
            begin
                cmd.latch_n = 1'b1;
                state_next  = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (sts.j_done)
                begin
                    state_next = (sts.op == OP_GET) ? S_EMIT : S_SET_DECIDE;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    cmd.ea_sel   = EA_J;
                    state_next   = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.scan   = 1'b1;
                cmd.j_inc  = 1'b1;
                state_next = S_SCAN_RD;
            end
            S_SET_DECIDE:
            begin
                priority if (sts.found)
                begin
                    cmd.ent_wr = 1'b1;
                    cmd.ea_sel = EA_HIT;
                    state_next = S_EMIT;
                end
                else if (sts.full)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.j_at_ins)
                begin
                    cmd.ent_wr = 1'b1;
                    cmd.ea_sel = EA_INS;
                    cmd.cnt_wr = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    cmd.ea_sel   = EA_JM1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.ent_wr       = 1'b1;
                cmd.ent_wr_shift = 1'b1;
                cmd.ea_sel       = EA_J;
                cmd.j_dec        = 1'b1;
                state_next       = S_SHIFT_RD;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_SIMPLE;
                    state_next    = S_IDLE;
                end
            end
            S_A_ROW:
            begin
                cmd.rd_count = 1'b1;
                state_next   = S_A_CNT;
            end
            S_A_CNT:
            begin
                cmd.latch_n = 1'b1;
                cmd.acc_clr = 1'b1;
                state_next  = S_A_ENT;
            end
            S_A_ENT:
            begin
                if (sts.j_done)
                begin
                    state_next = S_A_EMIT;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    cmd.ea_sel   = EA_J;
                    state_next   = S_A_VEC;
                end
            end
            S_A_VEC:
            begin
                cmd.rd_vec = 1'b1;
                state_next = S_A_MUL;
            end
            S_A_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_A_ACC;
            end
            S_A_ACC:
            begin
                cmd.acc_add = 1'b1;
                cmd.j_inc   = 1'b1;
                state_next  = S_A_ENT;
            end
            S_A_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_ROW;
                    if (sts.last_row)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = S_A_ROW;
                    end
                end
            end
            S_T_ROW:
            begin
                if (sts.i_done)
                begin
                    cmd.i_clr  = 1'b1;
                    state_next = S_T_COL;
                end
                else
                begin
                    cmd.rd_count   = 1'b1;
                    cmd.rd_vec     = 1'b1;
                    cmd.vec_addr_i = 1'b1;
                    state_next     = S_T_CNT;
                end
            end
            S_T_CNT:
            begin
                cmd.latch_n = 1'b1;
                state_next  = S_T_ENT;
            end
            S_T_ENT:
            begin
                if (sts.j_done)
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_T_ROW;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    cmd.ea_sel   = EA_J;
                    state_next   = S_T_ACC_RD;
                end
            end
            S_T_ACC_RD:
            begin
                cmd.rd_tacc = 1'b1;
                cmd.mul     = 1'b1;
                state_next  = S_T_ACC_WR;
            end
            S_T_ACC_WR:
            begin
                cmd.tacc_wr = 1'b1;
                cmd.j_inc   = 1'b1;
                state_next  = S_T_ENT;
            end
            S_T_COL:
            begin
                cmd.rd_tacc     = 1'b1;
                cmd.tacc_addr_i = 1'b1;
                state_next      = S_T_COL_EMIT;
            end
            S_T_COL_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_COL;
                    if (sts.last_col)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = S_T_COL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/srm_spmv_dpath.sv =====
`timescale 1ns / 1ps

module srm_spmv_dpath
    import srm_spmv_pkg::*;
#(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLUMNS  = 64,
    parameter int ROW_CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         op,
    input  logic [5:0]         row,
    input  logic [5:0]         column,
    input  logic signed [31:0] value,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] result_value,
    output logic [5:0]         position,
    output logic [1:0]         status,
    output logic               last
);

    localparam int VEC_DEPTH = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
    localparam int ENT_DEPTH = MAX_ROWS * ROW_CAPACITY;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int VEC_W     = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int TC_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ADDR_W    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int CNT_W     = $clog2(ROW_CAPACITY + 1);

    logic [2:0]         op_reg;
    logic [5:0]         row_reg;
    logic [5:0]         col_reg;
    logic signed [31:0] val_reg;
    logic [6:0]         rows_reg;
    logic [6:0]         cols_reg;
    logic [6:0]         i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   ins_reg;
    logic [CNT_W-1:0]   hit_reg;
    logic               found_reg;
    logic signed [31:0] hit_val_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;

    logic [MAX_ROWS-1:0]    row_valid_reg;
    logic [CNT_W-1:0]       cnt_mem [MAX_ROWS];
    logic [CNT_W-1:0]       cnt_q;
    logic                   cnt_vld_q;
    logic [5:0]             col_mem [ENT_DEPTH];
    logic signed [31:0]     ent_val_mem [ENT_DEPTH];
    logic [5:0]             ent_col_q;
    logic signed [31:0]     ent_val_q;
    logic [VEC_DEPTH-1:0]   vec_valid_reg;
    logic signed [31:0]     vec_mem [VEC_DEPTH];
    logic signed [31:0]     vec_q;
    logic                   vec_vld_q;
    logic [MAX_COLUMNS-1:0] tacc_valid_reg;
    logic signed [63:0]     tacc_mem [MAX_COLUMNS];
    logic signed [63:0]     tacc_q;
    logic                   tacc_vld_q;

    logic               out_valid_reg;
    logic [31:0]        result_value_reg;
    logic [5:0]         position_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    logic [6:0]         cfg_lim;
    logic [6:0]         cfg_dim;
    logic               cfg_wr;
    logic [6:0]         vec_lim;
    logic               sg_ok;
    logic               ld_ok;
    logic [CNT_W-1:0]   n_cur;
    logic [CNT_W-1:0]   ent_off;
    logic [ADDR_W-1:0]  ent_addr;
    logic [5:0]         ent_wcol;
    logic signed [31:0] ent_wval;
    logic [ROW_W-1:0]   row_idx;
    logic [VEC_W-1:0]   vec_raddr;
    logic [TC_W-1:0]    tacc_addr;
    logic signed [31:0] mul_b;
    logic signed [63:0] term;
    logic signed [63:0] tacc_cur;
    logic signed [63:0] e_sum;
    logic [5:0]         e_pos;
    logic [1:0]         e_st;
    logic               e_last;
    sat_t               e_sat;

    assign cfg_lim = (cfg_index == CFG_ROWS) ? 7'(MAX_ROWS) : 7'(MAX_COLUMNS);
    assign cfg_dim = (cfg_data == 7'd0) ? 7'd1 : ((cfg_data > cfg_lim) ? cfg_lim : cfg_data);
    assign cfg_wr  = cfg_valid && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS);
    assign vec_lim = (rows_reg > cols_reg) ? rows_reg : cols_reg;
    assign sg_ok   = ({1'b0, row_reg} < rows_reg) && ({1'b0, col_reg} < cols_reg);
    assign ld_ok   = {1'b0, col_reg} < vec_lim;
    assign n_cur   = cnt_vld_q ? cnt_q : '0;
    assign row_idx = i_reg[ROW_W-1:0];
    assign mul_b   = vec_vld_q ? vec_q : 32'sd0;
    assign term    = prod_reg >>> 16;
    assign tacc_cur = tacc_vld_q ? tacc_q : 64'sd0;

    always_comb
    begin
        unique case (cmd.ea_sel)
            EA_J:    ent_off = j_reg;
            EA_JM1:  ent_off = j_reg - 1'b1;
            EA_INS:  ent_off = ins_reg;
            EA_HIT:  ent_off = hit_reg;
            default: ent_off = j_reg;
        endcase
        ent_addr  = base_reg + ADDR_W'(ent_off);
        ent_wcol  = cmd.ent_wr_shift ? ent_col_q : col_reg;
        ent_wval  = cmd.ent_wr_shift ? ent_val_q : val_reg;
        vec_raddr = cmd.vec_addr_i ? i_reg[VEC_W-1:0] : ent_col_q[VEC_W-1:0];
        tacc_addr = cmd.tacc_addr_i ? i_reg[TC_W-1:0] : ent_col_q[TC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg       <= 7'(MAX_ROWS);
            cols_reg       <= 7'(MAX_COLUMNS);
            row_valid_reg  <= '0;
            vec_valid_reg  <= '0;
            tacc_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            ins_reg        <= '0;
            hit_reg        <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_ROWS)
            begin
                rows_reg <= cfg_dim;
            end
            if (cfg_valid && cfg_index == CFG_COLS)
            begin
                cols_reg <= cfg_dim;
            end
            if (cmd.clr_rows || cfg_wr)
            begin
                row_valid_reg <= '0;
            end
            else if (cmd.cnt_wr)
            begin
                row_valid_reg[row_idx] <= 1'b1;
            end
            if (cmd.vec_wr && ld_ok)
            begin
                vec_valid_reg[col_reg[VEC_W-1:0]] <= 1'b1;
            end
            if (cmd.tacc_clr_all)
            begin
                tacc_valid_reg <= '0;
            end
            else if (cmd.tacc_wr)
            begin
                tacc_valid_reg[tacc_addr] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.capture)
            begin
                i_reg     <= (op == OP_SET || op == OP_GET) ? {1'b0, row} : 7'd0;
                j_reg     <= '0;
                ins_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.i_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + 7'd1;
            end
            if (cmd.latch_n)
            begin
                n_reg <= n_cur;
                j_reg <= '0;
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + 1'b1;
            end
            else if (cmd.j_dec)
            begin
                j_reg <= j_reg - 1'b1;
            end
            if (cmd.scan)
            begin
                if (ent_col_q == col_reg)
                begin
                    found_reg <= 1'b1;
                    hit_reg   <= j_reg;
                end
                if (ent_col_q < col_reg)
                begin
                    ins_reg <= ins_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            row_reg <= row;
            col_reg <= column;
            val_reg <= value;
        end
        if (cmd.latch_n)
        begin
            base_reg <= ADDR_W'(row_idx) * ADDR_W'(ROW_CAPACITY);
        end
        if (cmd.scan && ent_col_q == col_reg)
        begin
            hit_val_reg <= ent_val_q;
        end
        if (cmd.mul)
        begin
            prod_reg <= ent_val_q * mul_b;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= 64'sd0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + term;
        end
        if (cmd.emit)
        begin
            result_value_reg <= e_sat.value;
            position_reg     <= e_pos;
            status_reg       <= e_sat.sat ? ST_SAT : e_st;
            last_reg         <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_wr)
        begin
            cnt_mem[row_idx] <= n_reg + 1'b1;
        end
        if (cmd.rd_count)
        begin
            cnt_q     <= cnt_mem[row_idx];
            cnt_vld_q <= row_valid_reg[row_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ent_wr)
        begin
            col_mem[ent_addr]     <= ent_wcol;
            ent_val_mem[ent_addr] <= ent_wval;
        end
        if (cmd.rd_entry)
        begin
            ent_col_q <= col_mem[ent_addr];
            ent_val_q <= ent_val_mem[ent_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vec_wr && ld_ok)
        begin
            vec_mem[col_reg[VEC_W-1:0]] <= val_reg;
        end
        if (cmd.rd_vec)
        begin
            vec_q     <= vec_mem[vec_raddr];
            vec_vld_q <= vec_valid_reg[vec_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tacc_wr)
        begin
            tacc_mem[tacc_addr] <= tacc_cur + term;
        end
        if (cmd.rd_tacc)
        begin
            tacc_q     <= tacc_mem[tacc_addr];
            tacc_vld_q <= tacc_valid_reg[tacc_addr];
        end
    end

    always_comb
    begin
        e_sum  = 64'sd0;
        e_pos  = 6'd0;
        e_st   = ST_OK;
        e_last = 1'b1;
        unique case (cmd.emit_kind)
            EK_ROW:
            begin
                e_sum  = acc_reg;
                e_pos  = i_reg[5:0];
                e_last = (i_reg + 7'd1) == rows_reg;
            end
            EK_COL:
            begin
                e_sum  = tacc_cur;
                e_pos  = i_reg[5:0];
                e_last = (i_reg + 7'd1) == cols_reg;
            end
            default:
            begin
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        e_st = ST_OK;
                    end
                    OP_SET:
                    begin
                        e_pos = row_reg;
                        priority if (!sg_ok)
                        begin
                            e_st = ST_RANGE;
                        end
                        else if (!found_reg && n_reg == CNT_W'(ROW_CAPACITY))
                        begin
                            e_st = ST_FULL;
                        end
                        else
                        begin
                            e_st = ST_OK;
                        end
                    end
                    OP_GET:
                    begin
                        e_pos = row_reg;
                        e_st  = sg_ok ? ST_OK : ST_RANGE;
                        if (sg_ok && found_reg)
                        begin
                            e_sum = 64'(hit_val_reg);
                        end
                    end
                    OP_LOAD:
                    begin
                        e_st = ld_ok ? ST_OK : ST_RANGE;
                    end
                    default:
                    begin
                        e_st = ST_RANGE;
                    end
                endcase
            end
        endcase
        e_sat = sat32(e_sum);
    end

    always_comb
    begin
        sts.op          = op_reg;
        sts.sg_in_range = sg_ok;
        sts.j_done      = j_reg == n_reg;
        sts.j_at_ins    = j_reg == ins_reg;
        sts.found       = found_reg;
        sts.full        = n_reg == CNT_W'(ROW_CAPACITY);
        sts.i_done      = i_reg == rows_reg;
        sts.last_row    = (i_reg + 7'd1) == rows_reg;
        sts.last_col    = (i_reg + 7'd1) == cols_reg;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign position     = position_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/sparse_row_matrix_store_spmv_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Beat
// in        input      in_valid / in_stall    op, row, column, value
// out       output     out_valid / out_stall  result_value, position, status, last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is processed at a time; the input is stalled until its last result is registered.
// Clear, load, unknown ops and out of range set or get go from dispatch straight to the emit.
// Get and set scan the n stored entries of the row; an insert then shifts each entry behind
// the insertion point up by one. Apply walks the n entries of each row; transposed apply walks
// every row, then emits each column; the single-port entry memory serializes entry accesses.
// Reset empties all rows and the vector; no memory sweep is needed.
// A stalled output holds the sequencer in place until the beat is taken.

module sparse_row_matrix_store_spmv_top
    import srm_spmv_pkg::*;
#(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLUMNS  = 64,
    parameter int ROW_CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic [5:0]         row,
    input  logic [5:0]         column,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [5:0]         position,
    output logic [1:0]         status,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    srm_spmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    srm_spmv_dpath #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .ROW_CAPACITY (ROW_CAPACITY)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .row          (row),
        .column       (column),
        .value        (value),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .position     (position),
        .status       (status),
        .last         (last)
    );

`ifndef SYNTHESIS
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted beat");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SAT |->
            result_value == 32'sh7fffffff || result_value == 32'sh80000000)
        else $error("saturated beat without a clamped value");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |-> result_value == 32'sd0 && last)
        else $error("out of range beat carries data");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> result_value == 32'sd0 && last)
        else $error("row full beat carries data");
`endif

endmodule

// ===== tb/sparse_row_matrix_store_spmv_top_test.sv =====
`timescale 1ns / 1ps

module sparse_row_matrix_store_spmv_top_test;
    import srm_spmv_pkg::*;

    localparam int N_ROWS = 64;
    localparam int N_COLS = 64;
    localparam int CAP    = 16;
    localparam longint CYCLE_LIMIT = 15000000;

    typedef struct packed {
        logic signed [31:0] val;
        logic [5:0]         pos;
        logic [1:0]         st;
        logic               lst;
    } spmv_result_t;

    class spmv_scoreboard;
        int unsigned rows_used;
        int unsigned cols_used;
        int unsigned fill [N_ROWS];
        logic [5:0]  col_at [N_ROWS][CAP];
        logic signed [31:0] val_at [N_ROWS][CAP];
        logic signed [31:0] xvec [N_COLS];
        spmv_result_t pending [$];
        int errors;

        function new();
            rows_used = N_ROWS;
            cols_used = N_COLS;
            errors = 0;
            foreach (fill[i]) fill[i] = 0;
            foreach (xvec[i]) xvec[i] = 0;
        endfunction

        function void write_dim(logic [1:0] idx, logic [6:0] d);
            int unsigned v;
            v = d;
            if (v < 1) v = 1;
            if (idx == CFG_ROWS)
            begin
                if (v > N_ROWS) v = N_ROWS;
                rows_used = v;
                foreach (fill[i]) fill[i] = 0;
            end
            else if (idx == CFG_COLS)
            begin
                if (v > N_COLS) v = N_COLS;
                cols_used = v;
                foreach (fill[i]) fill[i] = 0;
            end
        endfunction

        function longint fixmul(logic signed [31:0] a, logic signed [31:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> 16;
        endfunction

        function void push(longint sum, int unsigned pos, logic [1:0] st, bit lst);
            spmv_result_t r;
            r.st = st;
            if (sum > SUM_MAX)
            begin
                r.val = 32'h7fffffff;
                r.st = ST_SAT;
            end
            else if (sum < SUM_MIN)
            begin
                r.val = 32'h80000000;
                r.st = ST_SAT;
            end
            else
                r.val = sum[31:0];
            r.pos = pos[5:0];
            r.lst = lst;
            pending.push_back(r);
        endfunction

        function void note_input(logic [2:0] op, logic [5:0] r, logic [5:0] c,
                                 logic signed [31:0] v);
            int unsigned n, hit, ins, lim;
            bit found;
            longint acc;
            longint tacc [N_COLS];
            case (op)
                OP_CLEAR:
                begin
                    foreach (fill[i]) fill[i] = 0;
                    push(0, 0, ST_OK, 1);
                end
                OP_SET, OP_GET:
                begin
                    if (r >= rows_used || c >= cols_used)
                        push(0, r, ST_RANGE, 1);
                    else
                    begin
                        n = fill[r];
                        found = 0;
                        hit = 0;
                        for (int j = 0; j < n; j++)
                            if (col_at[r][j] == c)
                            begin
                                found = 1;
                                hit = j;
                            end
                        if (op == OP_GET)
                            push(found ? longint'(val_at[r][hit]) : 0, r, ST_OK, 1);
                        else if (found)
                        begin
                            val_at[r][hit] = v;
                            push(0, r, ST_OK, 1);
                        end
                        else if (n >= CAP)
                            push(0, r, ST_FULL, 1);
                        else
                        begin
                            ins = 0;
                            for (int j = 0; j < n; j++)
                                if (col_at[r][j] < c) ins = j + 1;
                            for (int j = n; j > ins; j--)
                            begin
                                col_at[r][j] = col_at[r][j-1];
                                val_at[r][j] = val_at[r][j-1];
                            end
                            col_at[r][ins] = c;
                            val_at[r][ins] = v;
                            fill[r] = n + 1;
                            push(0, r, ST_OK, 1);
                        end
                    end
                end
                OP_LOAD:
                begin
                    lim = rows_used > cols_used ? rows_used : cols_used;
                    if (c >= lim)
                        push(0, 0, ST_RANGE, 1);
                    else
                    begin
                        xvec[c] = v;
                        push(0, 0, ST_OK, 1);
                    end
                end
                OP_APPLY:
                    for (int i = 0; i < rows_used; i++)
                    begin
                        acc = 0;
                        for (int j = 0; j < fill[i]; j++)
                            acc += fixmul(val_at[i][j], xvec[col_at[i][j]]);
                        push(acc, i, ST_OK, i + 1 == rows_used);
                    end
                OP_APPLY_T:
                begin
                    foreach (tacc[k]) tacc[k] = 0;
                    for (int i = 0; i < rows_used; i++)
                        for (int j = 0; j < fill[i]; j++)
                            tacc[col_at[i][j]] += fixmul(val_at[i][j], xvec[i]);
                    for (int i = 0; i < cols_used; i++)
                        push(tacc[i], i, ST_OK, i + 1 == cols_used);
                end
                default:
                    push(0, 0, ST_RANGE, 1);
            endcase
        endfunction

        function void check_result(spmv_result_t got);
            spmv_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: val=%0d pos=%0d st=%0d last=%0d",
                             got.val, got.pos, got.st, got.lst);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp val=%0d pos=%0d st=%0d last=%0d, got val=%0d pos=%0d st=%0d last=%0d",
                             want.val, want.pos, want.st, want.lst,
                             got.val, got.pos, got.st, got.lst);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         op;
    logic [5:0]         row;
    logic [5:0]         column;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_value;
    logic [5:0]         position;
    logic [1:0]         status;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_data;

    spmv_scoreboard sb;
    longint cycles = 0;
    bit stall_quiet;

    sparse_row_matrix_store_spmv_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .row(row), .column(column), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_value(result_value), .position(position),
        .status(status), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_result({result_value, position, status, last});
    end

    always @(negedge clk)
    begin
        if (!rst_n || stall_quiet)
            out_stall <= 1'b0;
        else
            out_stall <= (gap_len() > 0) && ($urandom_range(0, 2) == 0);
    end

    task automatic send_item(logic [2:0] o, int unsigned r, int unsigned c,
                             logic signed [31:0] v);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        row <= r[5:0];
        column <= c[5:0];
        value <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(o, r[5:0], c[5:0], v);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] d);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_dim(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count, int rmax, int cmax);
        int p;
        logic [2:0] o;
        for (int k = 0; k < count; k++)
        begin
            p = $urandom_range(0, 99);
            if (p < 40) o = OP_SET;
            else if (p < 58) o = OP_GET;
            else if (p < 78) o = OP_LOAD;
            else if (p < 86) o = OP_APPLY;
            else if (p < 94) o = OP_APPLY_T;
            else if (p < 97) o = OP_CLEAR;
            else o = 3'($urandom_range(6, 7));
            send_item(o, $urandom_range(0, rmax), $urandom_range(0, cmax), rand_val());
        end
    endtask

    initial
    begin
        sb = new();
        stall_quiet = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_CLEAR;
        row = 0;
        column = 0;
        value = 0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_ROWS, 7'd4);
        write_reg(CFG_COLS, 7'd5);
        send_item(OP_LOAD, 0, 0, 32'sh7fffffff);
        send_item(OP_LOAD, 0, 1, 32'sh80000000);
        send_item(OP_LOAD, 0, 2, -32'sd65536);
        send_item(OP_LOAD, 0, 5, 32'sd1);
        send_item(OP_LOAD, 0, 63, 32'sd1);
        send_item(OP_SET, 0, 0, 32'sh7fffffff);
        send_item(OP_SET, 0, 0, 32'sh7fffffff);
        send_item(OP_SET, 1, 1, 32'sh7fffffff);
        send_item(OP_SET, 2, 2, -32'sd3);
        send_item(OP_SET, 2, 0, 32'sd65536);
        send_item(OP_SET, 4, 0, 32'sd1);
        send_item(OP_SET, 0, 5, 32'sd1);
        send_item(OP_GET, 2, 0, 0);
        send_item(OP_GET, 3, 3, 0);
        send_item(OP_GET, 63, 63, 0);
        send_item(OP_APPLY, 0, 0, 0);
        send_item(OP_APPLY_T, 0, 0, 0);
        send_item(3'd6, 63, 63, 32'shffffffff);
        send_item(3'd7, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_GET, 0, 0, 0);

        write_reg(CFG_ROWS, 7'd1);
        write_reg(CFG_COLS, 7'd40);
        for (int k = 0; k < 17; k++)
            send_item(OP_SET, 0, 39 - 2 * k, rand_val());
        send_item(OP_SET, 0, 39, 32'sd7);
        send_item(OP_APPLY, 0, 0, 0);
        send_item(OP_APPLY_T, 0, 0, 0);

        write_reg(CFG_ROWS, 7'd0);
        write_reg(CFG_COLS, 7'd127);
        write_reg(2'd2, 7'd3);
        write_reg(CFG_ROWS, 7'd8);
        write_reg(CFG_COLS, 7'd6);
        stall_quiet = 1;
        random_phase(120, 9, 8);
        stall_quiet = 0;
        random_phase(80, 9, 8);

        write_reg(CFG_ROWS, 7'd64);
        write_reg(CFG_COLS, 7'd64);
        random_phase(90, 63, 63);

        write_reg(CFG_ROWS, 7'd3);
        write_reg(CFG_COLS, 7'd64);
        random_phase(60, 4, 63);

        write_reg(CFG_ROWS, 7'd20);
        write_reg(CFG_COLS, 7'd1);
        random_phase(60, 22, 21);

        drain();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
